// ----- rtl/hlr_pkg.sv -----
// Shared types and constants of the histogram largest-rectangle block.
// No dependencies; hlr_area_max and histogram_largest_rectangle import this package.
`default_nettype none

package hlr_pkg;

   localparam int REQ_HEIGHT_BITS = 16;
   localparam int AREA_BITS = 26;
   localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};

   typedef struct packed {
      logic [REQ_HEIGHT_BITS-1:0] height;
      logic                       last_bar;
   } hlr_req_type;

   typedef struct packed {
      logic [AREA_BITS-1:0] max_area;
      logic                 overflow;
   } hlr_rsp_type;

   typedef struct packed {
      logic score;
      logic clear;
   } hlr_score_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/hlr_stream_if.sv -----
// Valid/ready channel that carries one request or one result per handshake.
// The payload type is a parameter; the block uses the structs of hlr_pkg.
`default_nettype none

interface hlr_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- rtl/hlr_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module hlr_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hlr_area_max.sv -----
// Scores popped stack entries: registered height times width, then saturation
// and a running maximum. Depends on hlr_pkg.
`default_nettype none

module hlr_area_max #(
   parameter int HW = 16,
   parameter int CW = 11
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire hlr_pkg::hlr_score_ctl_type      ctl,
   input  wire logic [HW-1:0]                   height,
   input  wire logic [CW-1:0]                   width,
   output logic      [hlr_pkg::AREA_BITS-1:0]   best
);

   import hlr_pkg::*;

   localparam int PW = HW + CW;
   localparam int XW = (PW > AREA_BITS) ? PW : AREA_BITS;

   logic [PW-1:0]        prod_ff;
   logic                 prod_vld_ff, prod_vld_in;
   logic [AREA_BITS-1:0] best_ff, best_in;
   logic [XW-1:0]        prod_x;
   logic [AREA_BITS-1:0] area;

   assign prod_x = XW'(prod_ff);
   assign area = (prod_x > XW'(AREA_MAX)) ? AREA_MAX : prod_x[AREA_BITS-1:0];

   always_comb begin
      prod_vld_in = ctl.score;
      best_in = best_ff;
      if (ctl.clear) begin
         prod_vld_in = 1'b0;
         best_in = '0;
      end else if (prod_vld_ff && (area > best_ff)) begin
         best_in = area;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         best_ff <= '0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(height) * PW'(width);
   end

   assign best = best_ff;

endmodule

`default_nettype wire

// ----- rtl/histogram_largest_rectangle.sv -----
// Top level of the histogram largest-rectangle block: stack sequencer, stack RAM
// and area scorer. Depends on hlr_pkg, hlr_stream_if, hlr_ram and hlr_area_max.
//
// Bars arrive on req_if one per request; the request with last_bar set closes
// the histogram and produces one result on rsp_if with the largest rectangle
// area and an overflow flag for bars beyond MAX_BARS, which are ignored. The
// stack lives in one RAM with a registered read, and its top entry is held in
// registers. Each bar is compared with the top entry; a pop reads the next
// entry from the RAM in a wait step (skipped when the pop empties the stack)
// and the bar is pushed once no pop is due. Every bar is popped once: the last
// bar is followed by flush pops and a finish step that posts the result. The
// pop rate is set by the read latency of the stack RAM. A finished result waits
// in its own register while the next histogram is taken in.
`default_nettype none

module histogram_largest_rectangle #(
   parameter int MAX_BARS = 1024,
   parameter int HEIGHT_BITS = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   hlr_stream_if.sink    req_if,
   hlr_stream_if.source  rsp_if
);

   import hlr_pkg::*;

   localparam int HW = (HEIGHT_BITS < REQ_HEIGHT_BITS) ? HEIGHT_BITS : REQ_HEIGHT_BITS;
   localparam int IW = $clog2(MAX_BARS);
   localparam int CW = $clog2(MAX_BARS + 1);
   localparam int EW = HW + IW;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          flush_ff, flush_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [HW-1:0]        h_ff, h_in;
   logic                 last_ff, last_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [IW-1:0]        left_ff, left_in;
   logic [HW-1:0]        top_h_ff, top_h_in;
   logic [IW-1:0]        top_left_ff, top_left_in;
   logic [AREA_BITS-1:0] rsp_area_ff, rsp_area_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic          ram_we, ram_re;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;

   hlr_score_ctl_type    score_ctl;
   logic [CW-1:0]        score_width;
   logic [AREA_BITS-1:0] best;
   logic                 pop;

   hlr_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_BARS)
   ) u_stack_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   hlr_area_max #(
      .HW(HW),
      .CW(CW)
   ) u_area_max (
      .clock(clock),
      .reset(reset),
      .ctl(score_ctl),
      .height(top_h_ff),
      .width(score_width),
      .best(best)
   );

   assign score_width = pos_ff - CW'(top_left_ff);
   assign pop = (depth_ff != '0) && (flush_ff || (top_h_ff >= h_ff));

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload.max_area = rsp_area_ff;
   assign rsp_if.payload.overflow = rsp_ovf_ff;

   always_comb begin
      state_in = state_ff;
      depth_in = depth_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      flush_in = flush_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      h_in = h_ff;
      last_in = last_ff;
      pos_in = pos_ff;
      left_in = left_ff;
      top_h_in = top_h_ff;
      top_left_in = top_left_ff;
      rsp_area_in = rsp_area_ff;
      rsp_ovf_in = rsp_ovf_ff;
      ram_we = 1'b0;
      ram_waddr = IW'(depth_ff - CW'(1));
      ram_wdata = {top_h_ff, top_left_ff};
      ram_re = 1'b0;
      ram_raddr = IW'(depth_ff - CW'(2));
      score_ctl = '{score: 1'b0, clear: 1'b0};

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               h_in = req_if.payload.height[HW-1:0];
               last_in = req_if.payload.last_bar;
               pos_in = count_ff;
               left_in = IW'(count_ff);
               if (count_ff == CW'(MAX_BARS)) begin
                  ovf_in = 1'b1;
                  if (req_if.payload.last_bar) begin
                     flush_in = 1'b1;
                     state_in = S_CHECK;
                  end
               end else begin
                  flush_in = 1'b0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (pop) begin
               score_ctl.score = 1'b1;
               left_in = top_left_ff;
               depth_in = depth_ff - CW'(1);
               if (depth_ff > CW'(1)) begin
                  ram_re = 1'b1;
                  state_in = S_WAIT;
               end
            end else if (flush_ff) begin
               state_in = S_FINISH;
            end else begin
               ram_we = (depth_ff != '0);
               top_h_in = h_ff;
               top_left_in = left_ff;
               depth_in = depth_ff + CW'(1);
               count_in = count_ff + CW'(1);
               if (last_ff) begin
                  flush_in = 1'b1;
                  pos_in = count_ff + CW'(1);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_WAIT: begin
            top_h_in = ram_rdata[EW-1:IW];
            top_left_in = ram_rdata[IW-1:0];
            state_in = S_CHECK;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_area_in = best;
               rsp_ovf_in = ovf_ff;
               score_ctl.clear = 1'b1;
               depth_in = '0;
               count_in = '0;
               ovf_in = 1'b0;
               flush_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         depth_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         flush_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         flush_ff <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      last_ff <= last_in;
      pos_ff <= pos_in;
      left_ff <= left_in;
      top_h_ff <= top_h_in;
      top_left_ff <= top_left_in;
      rsp_area_ff <= rsp_area_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // The stack never holds more entries than bars taken in.
   assert property (@(posedge clock) disable iff (reset) depth_ff <= count_ff)
      else $error("stack depth exceeds bar count");

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(MAX_BARS))
      else $error("bar count beyond capacity");

   // A refill read is only issued while entries remain below the top.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (depth_ff != '0))
      else $error("refill with empty stack");

   // A new result is only posted from the finish step, which clears the stack.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == S_FINISH)
         && (depth_ff == '0) && (count_ff == '0))
      else $error("result posted outside finish step");

endmodule

`default_nettype wire
